@@ src/acp_pkg.sv @@
// ----------------------------------------------------------------------------
// acp_pkg
// Shared types and constants for the alphabet code 3-bit packer.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int CHARS_W     = 56;
    localparam int LENGTH_W    = 3;
    localparam int CODE_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CHARS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LENGTH = 2'd1;

    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hff;

    // right shift of a code placed at the top of a byte, per slot
    localparam logic [2:0] SLOT_SHIFT [8] = '{3'd0, 3'd3, 3'd6, 3'd1,
                                              3'd4, 3'd7, 3'd2, 3'd5};

    // ones filled into the unused low bits on flush, per slot
    localparam logic [BYTE_W-1:0] FLUSH_FILL [8] = '{8'h00, 8'h1f, 8'h03, 8'h7f,
                                                     8'h0f, 8'h01, 8'h3f, 8'h07};

    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code;
    } acp_entry_t;

endpackage

@@ src/acp_front.sv @@
// ----------------------------------------------------------------------------
// acp_front
// Holds the alphabet registers, looks each byte up and queues its code.
// ----------------------------------------------------------------------------
module acp_front #(
    parameter int ALPHABET_SIZE = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acp_pkg::CHARS_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic [acp_pkg::BYTE_W-1:0]         data_byte,
    input  logic                               q_full,
    output logic                               push,
    output acp_pkg::acp_entry_t                push_entry
);
    import acp_pkg::*;

    localparam logic [LENGTH_W-1:0] SIZE_LIMIT = LENGTH_W'(ALPHABET_SIZE);

    logic [CHARS_W-1:0]  chars_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic [CODE_W-1:0]   prev_code_reg;
    logic [CODE_W-1:0]   prev_code_next;
    logic [LENGTH_W-1:0] limit;
    logic                hit;
    logic [CODE_W-1:0]   hit_code;
    logic [CODE_W-1:0]   code;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg  <= '0;
            length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_IDX_CHARS)
            begin
                chars_reg <= cfg_data;
            end
            else if (cfg_index == CFG_IDX_LENGTH)
            begin
                length_reg <= cfg_data[LENGTH_W-1:0];
            end
        end
    end

    // first match wins: scan from the top so the lowest index overrides
    always_comb
    begin
        limit    = (length_reg > SIZE_LIMIT) ? SIZE_LIMIT : length_reg;
        hit      = 1'b0;
        hit_code = '0;
        for (int i = ALPHABET_SIZE - 1; i >= 0; i--)
        begin
            if ((CODE_W'(i) < limit) && (chars_reg[BYTE_W*i +: BYTE_W] == data_byte))
            begin
                hit      = 1'b1;
                hit_code = CODE_W'(i);
            end
        end
    end

    assign code             = hit ? hit_code : prev_code_reg;
    assign push_entry.flush = (mode == MODE_FLUSH);
    assign push_entry.code  = code;

    always_comb
    begin
        prev_code_next = prev_code_reg;
        if (push)
        begin
            prev_code_next = (mode == MODE_FLUSH) ? '0 : code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_code_reg <= '0;
        end
        else
        begin
            prev_code_reg <= prev_code_next;
        end
    end

endmodule

@@ src/acp_queue.sv @@
// ----------------------------------------------------------------------------
// acp_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module acp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  acp_pkg::acp_entry_t   push_entry,
    input  logic                  pop,
    output acp_pkg::acp_entry_t   head_entry,
    output logic                  q_full,
    output logic                  q_empty,
    output logic [$clog2(DEPTH+1)-1:0] q_count
);
    import acp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    acp_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_full     = (count_reg == FULL_CNT);
    assign q_empty    = (count_reg == '0);
    assign q_count    = count_reg;
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/acp_back.sv @@
// ----------------------------------------------------------------------------
// acp_back
// Packs queued codes into bytes and emits flush padding through an
// output register.
// ----------------------------------------------------------------------------
module acp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  acp_pkg::acp_entry_t         head_entry,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [acp_pkg::BYTE_W-1:0]  packed_byte,
    output logic                        last,
    output logic                        stream_done
);
    import acp_pkg::*;

    logic [2:0]        slot_reg;
    logic [2:0]        slot_next;
    logic [BYTE_W-1:0] partial_reg;
    logic [BYTE_W-1:0] partial_next;
    logic              pend_reg;
    logic              pend_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    logic              last_reg;
    logic              last_next;
    logic              done_reg;
    logic              done_next;
    logic              can_load;
    logic [BYTE_W-1:0] top;
    logic [BYTE_W-1:0] merged;

    assign can_load = !out_valid_reg || !out_stall;
    assign top      = {head_entry.code, 5'b0};
    assign merged   = partial_reg | (top >> SLOT_SHIFT[slot_reg]);

    always_comb
    begin
        slot_next      = slot_reg;
        partial_next   = partial_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        pop            = 1'b0;
        if (can_load)
        begin
            out_valid_next = 1'b0;
            if (pend_reg)
            begin
                // second flush byte
                out_valid_next = 1'b1;
                byte_next      = PAD_BYTE;
                last_next      = 1'b1;
                done_next      = 1'b1;
                pend_next      = 1'b0;
            end
            else if (!q_empty)
            begin
                pop = 1'b1;
                if (head_entry.flush)
                begin
                    out_valid_next = 1'b1;
                    done_next      = 1'b1;
                    slot_next      = '0;
                    partial_next   = '0;
                    if (slot_reg == 3'd0)
                    begin
                        byte_next = PAD_BYTE;
                        last_next = 1'b1;
                    end
                    else
                    begin
                        byte_next = partial_reg | FLUSH_FILL[slot_reg];
                        pend_next = (slot_reg inside {3'd2, 3'd5});
                        last_next = !(slot_reg inside {3'd2, 3'd5});
                    end
                end
                else
                begin
                    slot_next = slot_reg + 3'd1;
                    case (slot_reg)
                        3'd2:
                        begin
                            out_valid_next = 1'b1;
                            partial_next   = {head_entry.code[0], 7'b0};
                        end
                        3'd5:
                        begin
                            out_valid_next = 1'b1;
                            partial_next   = {head_entry.code[1:0], 6'b0};
                        end
                        3'd7:
                        begin
                            out_valid_next = 1'b1;
                            partial_next   = '0;
                        end
                        default:
                        begin
                            partial_next = merged;
                        end
                    endcase
                    byte_next = merged;
                    last_next = 1'b1;
                    done_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            partial_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            partial_reg   <= partial_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign out_valid   = out_valid_reg;
    assign packed_byte = byte_reg;
    assign last        = last_reg;
    assign stream_done = done_reg;

endmodule

@@ src/alphabet_code_3bit_packer.sv @@
// ----------------------------------------------------------------------------
// alphabet_code_3bit_packer
// Maps bytes to 3-bit alphabet codes and packs them eight codes to three bytes.
// ----------------------------------------------------------------------------
// The input side takes one request per cycle while the queue (QUEUE_DEPTH
// entries) has room; the lookup is a parallel compare against the alphabet.
// The packer drains one queued request per cycle into a registered output
// while the output is not stalled and no 0xFF terminator is pending: a data
// request gives a byte on every third, sixth and eighth code of a group, and
// a flush at slot 2 or 5 sends the padded byte and then 0xFF. The queue lets
// new requests enter while a result waits in the output register.
// Configuration writes are always ready and take effect on the next cycle.
module alphabet_code_3bit_packer #(
    parameter int ALPHABET_SIZE = 7,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [acp_pkg::CHARS_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic [acp_pkg::BYTE_W-1:0]         data_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [acp_pkg::BYTE_W-1:0]         packed_byte,
    output logic                               last,
    output logic                               stream_done
);
    import acp_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic             q_full;
    logic             q_empty;
    logic             push;
    logic             pop;
    acp_entry_t       push_entry;
    acp_entry_t       head_entry;
    logic [CNT_W-1:0] q_count;

    acp_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    acp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_full     (q_full),
        .q_empty    (q_empty),
        .q_count    (q_count)
    );

    acp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head_entry  (head_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .packed_byte (packed_byte),
        .last        (last),
        .stream_done (stream_done)
    );

    // data bytes are always the only result of their request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stream_done |-> last)
        else $error("data byte without last");

    // queue never overfills and never pops empty
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH) && !(pop && q_empty))
        else $error("queue occupancy out of range");

    // a flush byte that is not last is followed by the 0xff terminator
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && stream_done && !last
        |=> out_valid && stream_done && last && packed_byte == PAD_BYTE)
        else $error("missing terminator byte after flush");

endmodule
